// ===== rtl/lprr_pkg.sv =====
// ----------------------------------------------------------------------------
// lprr_pkg
// Shared types and constants of the length-prefixed record ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lprr_pkg;

  localparam int unsigned RING_BYTES_DEF = 256;
  localparam int unsigned MAX_RECORD_DEF = 64;

  typedef enum logic [1:0] {
    MODE_BEGIN = 2'd0,
    MODE_DATA  = 2'd1,
    MODE_DEQ   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_ROOM = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_NO_OPEN = 3'd3,
    ST_BUSY    = 3'd4
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    wr_len;     // write length byte, open record
    logic    wr_data;    // write data byte of open record
    logic    rd;         // read ring at head, advance head
    logic    clear;      // reset pointers and fill count
    logic    len_latch;  // take length byte from read data
    logic    out_load;   // load a summary transaction
    logic    out_byte;   // load a dequeued byte transaction
    status_e status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fill_nz;
    logic too_long;
    logic no_room;
    logic empty;
    logic len_zero;
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/lprr_in_if.sv =====
// ----------------------------------------------------------------------------
// lprr_in_if
// Input channel: valid/ready handshake with one request per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lprr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] record_len;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output record_len, output data_byte,
                  input ready);
  modport sink   (input valid, input mode, input record_len, input data_byte,
                  output ready);
endinterface

// ===== rtl/lprr_out_if.sv =====
// ----------------------------------------------------------------------------
// lprr_out_if
// Result channel: valid/ready handshake with one result per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lprr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] data_byte_res;
  logic       byte_valid;
  logic       last;
  logic [7:0] used_bytes;
  logic [6:0] record_len_res;

  modport source (output valid, output status, output data_byte_res,
                  output byte_valid, output last, output used_bytes,
                  output record_len_res, input ready);
  modport sink   (input valid, input status, input data_byte_res,
                  input byte_valid, input last, input used_bytes,
                  input record_len_res, output ready);
endinterface

// ===== rtl/length_prefixed_record_ring_top.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_record_ring_top
// Byte ring of length-prefixed records: begin, fill, dequeue and clear.
// A non-dequeue request gives its result in the cycle after acceptance;
//   a new request is taken every cycle while the result side keeps up and no dequeue is in progress.
// In a dequeue, the length byte and each data byte of the record
//   come through the single registered read port of the ring memory.
// Reset clears pointers, fill count and state; the ring memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_record_ring_top
  import lprr_pkg::*;
#(
  parameter int unsigned RING_BYTES = RING_BYTES_DEF,
  parameter int unsigned MAX_RECORD = MAX_RECORD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lprr_in_if.sink    in_i,
  lprr_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  lprr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .mode_i     (in_i.mode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lprr_datapath #(
    .RING_BYTES (RING_BYTES),
    .MAX_RECORD (MAX_RECORD)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .record_len_i     (in_i.record_len),
    .data_byte_i      (in_i.data_byte),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .status_o         (out_o.status),
    .data_byte_res_o  (out_o.data_byte_res),
    .byte_valid_o     (out_o.byte_valid),
    .last_o           (out_o.last),
    .used_bytes_o     (out_o.used_bytes),
    .record_len_res_o (out_o.record_len_res)
  );

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.mode == MODE_CLEAR
    |=> out_o.valid && out_o.used_bytes == 8'd0 && out_o.status == ST_OK)
    else $error("clear did not empty the ring");

  a_busy_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.mode == MODE_DEQ && sts.fill_nz
    |=> out_o.valid && out_o.status == ST_BUSY && out_o.last)
    else $error("dequeue with open record not reported busy");

  a_byte_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.byte_valid |-> out_o.record_len_res != 7'd0)
    else $error("dequeued byte without record length");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.byte_valid |-> out_o.last)
    else $error("summary result not marked last");

endmodule

// ===== rtl/lprr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lprr_ctrl
// Controller: decodes requests and sequences record dequeue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lprr_ctrl
  import lprr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RDLEN = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          case (mode_i)
            MODE_BEGIN: begin
              cmd_o.out_load = 1'b1;
              if (sts_i.fill_nz) begin
                cmd_o.status = ST_BUSY;
              end else if (sts_i.too_long || sts_i.no_room) begin
                cmd_o.status = ST_NO_ROOM;
              end else begin
                cmd_o.wr_len = 1'b1;
                cmd_o.status = ST_OK;
              end
            end
            MODE_DATA: begin
              cmd_o.out_load = 1'b1;
              if (!sts_i.fill_nz) begin
                cmd_o.status = ST_NO_OPEN;
              end else begin
                cmd_o.wr_data = 1'b1;
                cmd_o.status  = ST_OK;
              end
            end
            MODE_DEQ: begin
              if (sts_i.fill_nz) begin
                cmd_o.out_load = 1'b1;
                cmd_o.status   = ST_BUSY;
              end else if (sts_i.empty) begin
                cmd_o.out_load = 1'b1;
                cmd_o.status   = ST_EMPTY;
              end else begin
                cmd_o.rd = 1'b1;
                state_d  = S_RDLEN;
              end
            end
            MODE_CLEAR: begin
              cmd_o.clear    = 1'b1;
              cmd_o.out_load = 1'b1;
              cmd_o.status   = ST_OK;
            end
            default: ;
          endcase
        end
      end
      S_RDLEN: begin
        cmd_o.len_latch = 1'b1;
        if (sts_i.len_zero) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.status   = ST_OK;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_byte = 1'b1;
          cmd_o.status   = ST_OK;
          if (sts_i.cnt_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/lprr_datapath.sv =====
// ----------------------------------------------------------------------------
// lprr_datapath
// Ring memory, head/tail pointers, fill and dequeue counters, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lprr_datapath
  import lprr_pkg::*;
#(
  parameter int unsigned RING_BYTES = RING_BYTES_DEF,
  parameter int unsigned MAX_RECORD = MAX_RECORD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] record_len_i,
  input  logic [7:0] data_byte_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [2:0] status_o,
  output logic [7:0] data_byte_res_o,
  output logic       byte_valid_o,
  output logic       last_o,
  output logic [7:0] used_bytes_o,
  output logic [6:0] record_len_res_o
);

  localparam int unsigned PW = $clog2(RING_BYTES);
  localparam int unsigned CW = ((PW > 8) ? PW : 8) + 2;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    adv = (p == PW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] used_of(input logic [PW-1:0] h, input logic [PW-1:0] t);
    logic [PW:0] wrap;
    wrap = {1'b0, t} + (PW+1)'(RING_BYTES) - {1'b0, h};
    used_of = (t >= h) ? (t - h) : wrap[PW-1:0];
  endfunction

  logic [7:0]    mem [RING_BYTES];
  logic [7:0]    rd_data_q;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [6:0]    fill_q, cnt_q, rlen_q;
  logic [PW-1:0] used_after_q, used_now, used_d;
  logic [6:0]    len_clamp;
  logic [CW-1:0] need;

  logic          out_valid_q;
  logic [2:0]    status_q;
  logic [7:0]    data_q;
  logic          byte_valid_q, last_q;
  logic [PW-1:0] used_q;
  logic [6:0]    rlen_out_q;

  always_comb begin
    head_d = cmd_i.clear ? '0 : (cmd_i.rd ? adv(head_q) : head_q);
    tail_d = cmd_i.clear ? '0 :
             ((cmd_i.wr_len || cmd_i.wr_data) ? adv(tail_q) : tail_q);
    used_now  = used_of(head_q, tail_q);
    used_d    = used_of(head_d, tail_d);
    len_clamp = (rd_data_q > 8'(MAX_RECORD)) ? 7'(MAX_RECORD) : rd_data_q[6:0];
    need      = CW'(used_now) + CW'(record_len_i) + CW'(1);
  end

  assign sts_o.fill_nz  = (fill_q != '0);
  assign sts_o.too_long = (record_len_i > 8'(MAX_RECORD));
  assign sts_o.no_room  = (need > CW'(RING_BYTES - 1));
  assign sts_o.empty    = (head_q == tail_q);
  assign sts_o.len_zero = (len_clamp == '0);
  assign sts_o.cnt_last = (cnt_q == 7'd1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_len) begin
      mem[tail_q] <= record_len_i;
    end else if (cmd_i.wr_data) begin
      mem[tail_q] <= data_byte_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      if (cmd_i.clear) begin
        fill_q <= '0;
      end else if (cmd_i.wr_len) begin
        fill_q <= record_len_i[6:0];
      end else if (cmd_i.wr_data) begin
        fill_q <= fill_q - 7'd1;
      end
      if (cmd_i.len_latch) begin
        cnt_q <= len_clamp;
      end else if (cmd_i.out_byte) begin
        cnt_q <= cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_latch) begin
      rlen_q       <= len_clamp;
      used_after_q <= used_now - PW'(len_clamp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load || cmd_i.out_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q     <= cmd_i.status;
      data_q       <= '0;
      byte_valid_q <= 1'b0;
      last_q       <= 1'b1;
      used_q       <= used_d;
      rlen_out_q   <= '0;
    end else if (cmd_i.out_byte) begin
      status_q     <= cmd_i.status;
      data_q       <= rd_data_q;
      byte_valid_q <= 1'b1;
      last_q       <= (cnt_q == 7'd1);
      used_q       <= used_after_q;
      rlen_out_q   <= rlen_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign data_byte_res_o  = data_q;
  assign byte_valid_o     = byte_valid_q;
  assign last_o           = last_q;
  assign used_bytes_o     = 8'(used_q);
  assign record_len_res_o = rlen_out_q;

endmodule

// ===== tb/sv/tb_length_prefixed_record_ring_top.sv =====
// ----------------------------------------------------------------------------
// tb_length_prefixed_record_ring_top
// Self-checking bench for the length-prefixed record ring. A short table of
// requests covers the corner cases: empty ring, no open record, too long,
// zero-length record, busy while a record is open, clear while open. Random
// traffic follows. It first fills the ring until a begin is refused for lack
// of room. It then mixes whole records, dequeues, clears, stray requests and
// records cut short. Both handshake sides pause at random. Every result
// transaction is compared field by field with the table or a behavioral copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_length_prefixed_record_ring_top;
  import lprr_pkg::*;

  localparam int unsigned RING = RING_BYTES_DEF;
  localparam int unsigned MAX_REC = MAX_RECORD_DEF;

  typedef struct packed {
    status_e    status;
    logic [7:0] data;
    logic       bvalid;
    logic       last;
    logic [7:0] used;
    logic [6:0] rlen;
  } ring_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lprr_in_if  in_if ();
  lprr_out_if out_if ();

  length_prefixed_record_ring_top #(
    .RING_BYTES(RING),
    .MAX_RECORD(MAX_REC)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #2 clk_i = ~clk_i;

  // shadow copy of the ring
  logic [7:0]  shadow_mem [RING];
  int unsigned rd_ptr, wr_ptr, fill_left;

  ring_result_t step_out [$];
  ring_result_t pending_results [$];
  ring_result_t front_exp;
  status_e      last_status;

  bit gaps_on;
  int unsigned n_errors, n_items, n_results, n_records, n_no_room;
  int unsigned stall_left;

  function automatic int unsigned ring_used();
    return (wr_ptr + RING - rd_ptr) % RING;
  endfunction

  function automatic void ring_step(input mode_e m, input logic [7:0] len,
                                    input logic [7:0] dbyte);
    ring_result_t r;
    logic [7:0]   bytes [$];
    int unsigned  rec_len;
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    step_out.delete();
    case (m)
      MODE_BEGIN: begin
        if (fill_left != 0) begin
          r.status = ST_BUSY;
        end else if (len > MAX_REC || ring_used() + len + 1 > RING - 1) begin
          r.status = ST_NO_ROOM;
        end else begin
          shadow_mem[wr_ptr] = len;
          wr_ptr = (wr_ptr + 1) % RING;
          fill_left = len;
        end
      end
      MODE_DATA: begin
        if (fill_left == 0) begin
          r.status = ST_NO_OPEN;
        end else begin
          shadow_mem[wr_ptr] = dbyte;
          wr_ptr = (wr_ptr + 1) % RING;
          fill_left--;
        end
      end
      MODE_DEQ: begin
        if (fill_left != 0) begin
          r.status = ST_BUSY;
        end else if (rd_ptr == wr_ptr) begin
          r.status = ST_EMPTY;
        end else begin
          rec_len = shadow_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % RING;
          if (rec_len > MAX_REC) rec_len = MAX_REC;
          for (int unsigned i = 0; i < rec_len; i++) begin
            bytes.push_back(shadow_mem[rd_ptr]);
            rd_ptr = (rd_ptr + 1) % RING;
          end
          for (int unsigned i = 0; i < rec_len; i++) begin
            r.data = bytes[i];
            r.bvalid = 1'b1;
            r.last = (i + 1 == rec_len);
            r.used = 8'(ring_used());
            r.rlen = 7'(rec_len);
            step_out.push_back(r);
          end
        end
      end
      default: begin
        rd_ptr = 0;
        wr_ptr = 0;
        fill_left = 0;
      end
    endcase
    if (step_out.size() == 0) begin
      r.used = 8'(ring_used());
      step_out.push_back(r);
    end
    last_status = step_out[0].status;
  endfunction

  task automatic send_req(input mode_e m, input logic [7:0] len, input logic [7:0] dbyte,
                          input bit typed, input status_e t_st, input logic [7:0] t_used);
    ring_result_t t;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.record_len <= len;
    in_if.data_byte  <= dbyte;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    ring_step(m, len, dbyte);
    if (typed) begin
      t = '0;
      t.status = t_st;
      t.last = 1'b1;
      t.used = t_used;
      pending_results.push_back(t);
    end else begin
      foreach (step_out[i]) pending_results.push_back(step_out[i]);
    end
    if (m == MODE_DEQ && step_out[0].bvalid) n_records++;
    if (last_status == ST_NO_ROOM) n_no_room++;
    n_items++;
  endtask

  task automatic put(input mode_e m, input logic [7:0] len, input logic [7:0] dbyte);
    send_req(m, len, dbyte, 1'b0, ST_OK, 8'd0);
  endtask

  task automatic row(input mode_e m, input logic [7:0] len, input logic [7:0] dbyte,
                     input status_e st, input logic [7:0] used);
    send_req(m, len, dbyte, 1'b1, st, used);
  endtask

  task automatic fill_open_record();
    while (fill_left != 0) put(MODE_DATA, 8'($urandom), 8'($urandom));
  endtask

  task automatic enqueue_record(input logic [7:0] len);
    put(MODE_BEGIN, len, 8'($urandom));
    if (last_status == ST_OK) fill_open_record();
  endtask

  task automatic drain_wait();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_len();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return 8'($urandom_range(0, 12));
    if (sel <= 7) return 8'($urandom_range(13, MAX_REC - 1));
    if (sel == 8) return 8'(MAX_REC);
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // result side: check and random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t ns: unexpected result transaction, expected none, actual status %0d",
                 $time, out_if.status);
      end else begin
        front_exp = pending_results.pop_front();
        n_results++;
        check_field("status", 8'(front_exp.status), 8'(out_if.status));
        check_field("data_byte_res", front_exp.data, out_if.data_byte_res);
        check_field("byte_valid", 8'(front_exp.bvalid), 8'(out_if.byte_valid));
        check_field("last", 8'(front_exp.last), 8'(out_if.last));
        check_field("used_bytes", front_exp.used, out_if.used_bytes);
        check_field("record_len_res", 8'(front_exp.rlen), 8'(out_if.record_len_res));
      end
    end
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("tb_length_prefixed_record_ring_top: errors");
    $finish;
  end

  initial begin
    int unsigned sel;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_BEGIN;
    in_if.record_len = 8'd0;
    in_if.data_byte  = 8'd0;
    rd_ptr = 0;
    wr_ptr = 0;
    fill_left = 0;
    gaps_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner cases
    row(MODE_DEQ,   8'd0,   8'd0,   ST_EMPTY,   8'd0);
    row(MODE_DATA,  8'd0,   8'h5A,  ST_NO_OPEN, 8'd0);
    row(MODE_BEGIN, 8'd65,  8'd0,   ST_NO_ROOM, 8'd0);
    row(MODE_BEGIN, 8'd255, 8'hFF,  ST_NO_ROOM, 8'd0);
    row(MODE_BEGIN, 8'd0,   8'd0,   ST_OK,      8'd1);
    row(MODE_DEQ,   8'd0,   8'd0,   ST_OK,      8'd0);
    row(MODE_BEGIN, 8'd64,  8'd0,   ST_OK,      8'd1);
    row(MODE_BEGIN, 8'd3,   8'd0,   ST_BUSY,    8'd1);
    row(MODE_DEQ,   8'd0,   8'd0,   ST_BUSY,    8'd1);
    row(MODE_DATA,  8'd0,   8'hA5,  ST_OK,      8'd2);
    row(MODE_CLEAR, 8'd0,   8'd0,   ST_OK,      8'd0);
    row(MODE_BEGIN, 8'd2,   8'd0,   ST_OK,      8'd1);
    row(MODE_DATA,  8'd0,   8'h00,  ST_OK,      8'd2);
    row(MODE_DATA,  8'd0,   8'hFF,  ST_OK,      8'd3);
    put(MODE_DEQ,   8'd0,   8'd0);
    row(MODE_DEQ,   8'd0,   8'd0,   ST_EMPTY,   8'd0);
    row(MODE_BEGIN, 8'd1,   8'd0,   ST_OK,      8'd1);
    row(MODE_DATA,  8'd0,   8'h81,  ST_OK,      8'd2);
    row(MODE_CLEAR, 8'hFF,  8'hFF,  ST_OK,      8'd0);
    row(MODE_CLEAR, 8'd0,   8'd0,   ST_OK,      8'd0);
    row(MODE_DATA,  8'hFF,  8'h7E,  ST_NO_OPEN, 8'd0);

    // fill until a begin is refused, then free some room
    do begin
      enqueue_record(8'($urandom_range(32, MAX_REC)));
    end while (last_status == ST_OK);
    put(MODE_DEQ, 8'($urandom), 8'($urandom));
    put(MODE_DEQ, 8'($urandom), 8'($urandom));
    drain_wait();

    while (n_items < 310) begin
      gaps_on = (n_items < 285) && ((n_items / 40) % 3 != 2);
      if (fill_left != 0 && $urandom_range(0, 3) != 0) fill_open_record();
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        enqueue_record(pick_len());
      end else if (sel < 80) begin
        put(MODE_DEQ, 8'($urandom), 8'($urandom));
      end else if (sel < 83) begin
        put(MODE_CLEAR, 8'($urandom), 8'($urandom));
      end else if (sel < 93) begin
        put(mode_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end else begin
        // record cut short by a begin, a dequeue or a clear
        put(MODE_BEGIN, 8'($urandom_range(1, MAX_REC)), 8'($urandom));
        if (last_status == ST_OK) begin
          repeat ($urandom_range(0, fill_left - 1)) put(MODE_DATA, 8'($urandom), 8'($urandom));
          sel = $urandom_range(0, 2);
          put(sel == 0 ? MODE_BEGIN : (sel == 1 ? MODE_DEQ : MODE_CLEAR),
              8'($urandom), 8'($urandom));
        end
      end
    end
    gaps_on = 1'b0;
    fill_open_record();
    drain_wait();
    repeat (80) @(posedge clk_i);

    $display("run covered %0d requests and %0d result transactions, %0d records dequeued,",
             n_items, n_results, n_records);
    $display("with %0d begins refused for length or room", n_no_room);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("tb_length_prefixed_record_ring_top: clean");
    end else begin
      $display("tb_length_prefixed_record_ring_top: errors");
    end
    $finish;
  end

endmodule
